// ===== rtl/core/wrst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted random selection table: shared definitions
// Sizes, operation codes and the request and result words of the table.
// ----------------------------------------------------------------------------
package wrst_pkg;

	localparam int KEYS     = 1024;
	localparam int KEY_W    = 10;
	localparam int WEIGHT_W = 32;
	localparam int RAND_W   = 32;
	localparam int TOTAL_W  = 42;
	localparam int COUNT_W  = 11;

	typedef enum logic [2:0] {
		OP_SET    = 3'd0,
		OP_REMOVE = 3'd1,
		OP_CLEAR  = 3'd2,
		OP_WDRAW  = 3'd3,
		OP_UDRAW  = 3'd4
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [KEY_W-1:0]    key;
		logic [WEIGHT_W-1:0] weight;
		logic [RAND_W-1:0]   random_value;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0]   chosen_key;
		logic               chosen_valid;
		logic [COUNT_W-1:0] entry_count;
	} res_t;

endpackage

// ===== rtl/core/wrst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weight memory
// Simple dual-port synchronous RAM with one write and one registered read port.
// ----------------------------------------------------------------------------
module wrst_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/wrst_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring division that yields the remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module wrst_mod
	import wrst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RAND_W-1:0]  dividend,
	input  logic [COUNT_W-1:0] divisor,
	output logic               done,
	output logic [COUNT_W-1:0] remainder
);

	localparam int CNT_W = $clog2(RAND_W + 1);

	logic [RAND_W-1:0]  dvd_q;
	logic [COUNT_W-1:0] div_q;
	logic [COUNT_W-1:0] rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [COUNT_W:0]   trial;
	logic [COUNT_W:0]   diff;

	assign trial = {rem_q, dvd_q[RAND_W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RAND_W);
				dvd_q  <= dividend;
				div_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				dvd_q <= {dvd_q[RAND_W-2:0], 1'b0};
				if (trial >= {1'b0, div_q}) begin
					rem_q <= diff[COUNT_W-1:0];
				end else begin
					rem_q <= trial[COUNT_W-1:0];
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/weighted_random_selection_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted random selection table
// Keeps a Q16.16 weight per key and draws keys by weight or uniformly.
// ----------------------------------------------------------------------------
// Usage: a request (op, key, weight, random_value) is taken when req_valid is
// high and req_stall low; exactly one result (chosen_key, chosen_valid,
// entry_count) follows on res_valid, held until res_stall is low.
// The block works on one request at a time; req_stall stays high meanwhile.
// Set weight and remove take one weight memory read, then one read-modify-write.
// A weighted draw forms its threshold in the multiply and threshold states,
// then walks the keys in order up to the chosen key, reading one weight per
// cycle through the single read port. A uniform draw first runs the
// bit-serial remainder unit, then the same walk.
// Clear sweeps the weight memory, one entry a cycle.
// After reset the same sweep runs with req_stall high.
// A result that waits on res_stall stays in the output register while the
// next request is taken and worked on; that request's result then holds the
// block in its output state until the register is free.
// ----------------------------------------------------------------------------
module weighted_random_selection_table_unit
	import wrst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_SET, ST_MUL, ST_THR, ST_DIV, ST_WALK, ST_OUT
	} state_t;

	state_t               state_q;
	op_t                  op_q;
	logic [KEY_W-1:0]     key_q;
	logic [WEIGHT_W-1:0]  w_q;
	logic [RAND_W-1:0]    r_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [COUNT_W-1:0]   count_q;
	logic [KEY_W-1:0]     clr_q;
	logic                 clr_res_q;
	logic [KEY_W-1:0]     cur_q;
	logic [TOTAL_W-1:0]   run_q;
	logic [COUNT_W-1:0]   seen_q;
	logic [COUNT_W-1:0]   pos_q;
	logic [TOTAL_W-1:0]   thr_q;
	logic [63:0]          plo_q;
	logic [TOTAL_W-1:0]   phi_q;
	logic [KEY_W-1:0]     ch_key_q;
	logic                 ch_vld_q;
	logic                 res_valid_q;
	res_t                 res_q;

	logic                 accept;
	logic                 out_load;
	logic                 we;
	logic [KEY_W-1:0]     waddr;
	logic [WEIGHT_W-1:0]  wdata;
	logic [KEY_W-1:0]     raddr;
	logic [WEIGHT_W-1:0]  rdata;
	logic                 div_start;
	logic                 div_done;
	logic [COUNT_W-1:0]   div_rem;
	logic                 hit;
	logic [TOTAL_W-1:0]   run_next;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_load  = (state_q == ST_OUT) && (!res_valid_q || !res_stall);
	assign div_start = accept && (req.op == OP_UDRAW) && (count_q != '0);
	assign run_next  = run_q + TOTAL_W'(rdata);

	always_comb begin
		if (op_q == OP_WDRAW) begin
			hit = (rdata != '0) && (run_next > thr_q);
		end else begin
			hit = (rdata != '0) && (seen_q == pos_q);
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = '0;
		raddr = '0;
		case (state_q)
			ST_IDLE: raddr = req.key;
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			ST_SET: begin
				we    = (w_q != '0) || (rdata != '0);
				waddr = key_q;
				wdata = w_q;
			end
			ST_WALK: begin
				we    = hit;
				raddr = cur_q + 1'b1;
			end
			default: raddr = '0;
		endcase
	end

	wrst_ram #(
		.DEPTH(KEYS),
		.WIDTH(WEIGHT_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	wrst_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.random_value),
		.divisor  (count_q),
		.done     (div_done),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			clr_res_q   <= 1'b0;
			total_q     <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == KEY_W'(KEYS - 1)) begin
						total_q <= '0;
						count_q <= '0;
						state_q <= clr_res_q ? ST_OUT : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						op_q     <= req.op;
						key_q    <= req.key;
						w_q      <= req.weight;
						r_q      <= req.random_value;
						ch_key_q <= '0;
						ch_vld_q <= 1'b0;
						cur_q    <= '0;
						run_q    <= '0;
						seen_q   <= '0;
						case (req.op)
							OP_SET: state_q <= ST_SET;
							OP_REMOVE: begin
								w_q     <= '0;
								state_q <= ST_SET;
							end
							OP_CLEAR: begin
								clr_q     <= '0;
								clr_res_q <= 1'b1;
								state_q   <= ST_CLR;
							end
							OP_WDRAW: state_q <= (count_q != '0) ? ST_MUL : ST_OUT;
							OP_UDRAW: state_q <= (count_q != '0) ? ST_DIV : ST_OUT;
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_SET: begin
					total_q <= total_q - TOTAL_W'(rdata) + TOTAL_W'(w_q);
					if ((w_q != '0) && (rdata == '0)) begin
						count_q <= count_q + 1'b1;
					end else if ((w_q == '0) && (rdata != '0)) begin
						count_q <= count_q - 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_MUL: begin
					plo_q   <= 64'(total_q[31:0]) * 64'(r_q);
					phi_q   <= TOTAL_W'(total_q[TOTAL_W-1:32]) * TOTAL_W'(r_q);
					state_q <= ST_THR;
				end
				ST_THR: begin
					thr_q   <= phi_q + TOTAL_W'(plo_q[63:32]);
					state_q <= ST_WALK;
				end
				ST_DIV: begin
					if (div_done) begin
						pos_q   <= div_rem;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					cur_q <= cur_q + 1'b1;
					if (hit) begin
						total_q  <= total_q - TOTAL_W'(rdata);
						count_q  <= count_q - 1'b1;
						ch_key_q <= cur_q;
						ch_vld_q <= 1'b1;
						state_q  <= ST_OUT;
					end else begin
						if (rdata != '0) begin
							run_q  <= run_next;
							seen_q <= seen_q + 1'b1;
						end
						if (cur_q == KEY_W'(KEYS - 1)) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						res_q.chosen_key   <= ch_key_q;
						res_q.chosen_valid <= ch_vld_q;
						res_q.entry_count  <= count_q;
						clr_res_q          <= 1'b0;
						state_q            <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== tb/wrst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted random selection table: result checker
// Watches the request and result channels, keeps its own copy of the weight
// table, works out the expected result of each accepted request and compares
// every result field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module wrst_checker
	import wrst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic res_valid,
	input  logic res_stall,
	input  res_t res,
	output int   errors,
	output int   pending,
	output int   draws_found,
	output int   draws_empty
);

	logic [WEIGHT_W-1:0] table_weight [KEYS];
	logic [TOTAL_W-1:0]  table_total;
	logic [COUNT_W-1:0]  table_count;
	res_t                expected_results [$];

	function automatic void drop_key(input int k);
		if (table_weight[k] != '0) begin
			table_total     = table_total - table_weight[k];
			table_weight[k] = '0;
			table_count     = table_count - 1'b1;
		end
	endfunction

	function automatic res_t table_result(input req_t r);
		res_t   o;
		logic [73:0] prod;
		logic [TOTAL_W-1:0] thresh;
		logic [TOTAL_W-1:0] run;
		int     pos;
		int     seen;
		o = '0;
		case (r.op)
			OP_SET: begin
				if (r.weight == '0) begin
					drop_key(r.key);
				end else begin
					if (table_weight[r.key] != '0)
						table_total = table_total - table_weight[r.key];
					else
						table_count = table_count + 1'b1;
					table_weight[r.key] = r.weight;
					table_total = table_total + r.weight;
				end
			end
			OP_REMOVE: drop_key(r.key);
			OP_CLEAR: begin
				foreach (table_weight[k])
					table_weight[k] = '0;
				table_total = '0;
				table_count = '0;
			end
			OP_WDRAW: begin
				if (table_count != '0) begin
					prod   = 74'(table_total) * 74'(r.random_value);
					thresh = prod[73:32];
					run    = '0;
					for (int k = 0; k < KEYS; k++) begin
						if (table_weight[k] != '0) begin
							run = run + table_weight[k];
							if (run > thresh) begin
								o.chosen_key   = KEY_W'(k);
								o.chosen_valid = 1'b1;
								drop_key(k);
								break;
							end
						end
					end
				end
			end
			OP_UDRAW: begin
				if (table_count != '0) begin
					pos  = int'(r.random_value % 32'(table_count));
					seen = 0;
					for (int k = 0; k < KEYS; k++) begin
						if (table_weight[k] != '0) begin
							if (seen == pos) begin
								o.chosen_key   = KEY_W'(k);
								o.chosen_valid = 1'b1;
								drop_key(k);
								break;
							end
							seen++;
						end
					end
				end
			end
			default: ;
		endcase
		o.entry_count = table_count;
		return o;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		int   err_n;
		if (!arst_n) begin
			foreach (table_weight[k])
				table_weight[k] = '0;
			table_total = '0;
			table_count = '0;
			expected_results.delete();
			errors      <= 0;
			draws_found <= 0;
			draws_empty <= 0;
		end else begin
			err_n = 0;
			if (req_valid && !req_stall) begin
				e = table_result(req);
				expected_results.push_back(e);
				if (req.op == OP_WDRAW || req.op == OP_UDRAW) begin
					if (e.chosen_valid)
						draws_found <= draws_found + 1;
					else
						draws_empty <= draws_empty + 1;
				end
			end
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, res);
					err_n++;
				end else begin
					e = expected_results.pop_front();
					if (res.chosen_key !== e.chosen_key) begin
						$display("%0t: chosen_key expected %0d actual %0d",
							$time, e.chosen_key, res.chosen_key);
						err_n++;
					end
					if (res.chosen_valid !== e.chosen_valid) begin
						$display("%0t: chosen_valid expected %0d actual %0d",
							$time, e.chosen_valid, res.chosen_valid);
						err_n++;
					end
					if (res.entry_count !== e.entry_count) begin
						$display("%0t: entry_count expected %0d actual %0d",
							$time, e.entry_count, res.entry_count);
						err_n++;
					end
				end
			end
			if (err_n != 0)
				errors <= errors + err_n;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted random selection table: testbench top
// Drives directed and random requests with bursty gaps, stalls the result
// side on its own pattern including one long hold-off, and reports the
// verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb_top;
	import wrst_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic res_valid;
	logic res_stall;
	res_t res;
	int   errors;
	int   pending;
	int   draws_found;
	int   draws_empty;
	int   requests_sent;
	bit   long_hold;
	bit   long_hold_done;

	weighted_random_selection_table_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	wrst_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.errors(errors), .pending(pending),
		.draws_found(draws_found), .draws_empty(draws_empty)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("Timeout with %0d results outstanding", pending);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Offers one request and holds it until accepted; the next request may
	// follow at once, so valid is never dropped between back-to-back requests.
	task automatic send(input req_t r);
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		requests_sent++;
	endtask

	task automatic maybe_gap();
		int g;
		if ($urandom_range(0, 3) == 0) begin
			g = $urandom_range(1, 6);
			req_valid <= 1'b0;
			req       <= req_t'($bits(req_t)'({$urandom, $urandom, $urandom}));
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic req_t make_req(input op_t op, input int key,
		input logic [31:0] w, input logic [31:0] rv);
		req_t r;
		r.op           = op;
		r.key          = KEY_W'(key);
		r.weight       = w;
		r.random_value = rv;
		return r;
	endfunction

	function automatic int small_key();
		return $urandom_range(0, 99) < 80 ? $urandom_range(0, 40) : $urandom_range(0, KEYS-1);
	endfunction

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(0, 4))
			0: return 32'hFFFF_FFFF;
			1: return $urandom_range(1, 16);
			2: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	// Receiver: random stall pattern, quiet stretches, and one long hold-off.
	initial begin
		int mode;
		int len;
		res_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (long_hold && !long_hold_done) begin
				res_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				long_hold_done = 1'b1;
			end
			mode = $urandom_range(0, 3);
			len  = $urandom_range(1, 40);
			repeat (len) begin
				res_stall <= (mode == 0) ? 1'b0 :
					(mode == 1) ? 1'b1 : ($urandom_range(0, 2) == 0);
				@(posedge clk);
			end
		end
	end

	initial begin
		logic [31:0] w;
		op_t         op;
		int          n;
		req_valid     = 1'b0;
		req           = '0;
		arst_n        = 1'b0;
		requests_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: draws on an empty table, extreme weights and keys.
		send(make_req(OP_WDRAW, 0, 0, 32'hFFFF_FFFF));
		send(make_req(OP_UDRAW, 0, 0, 32'h0));
		send(make_req(OP_SET, 0, 32'hFFFF_FFFF, 0));
		send(make_req(OP_SET, KEYS-1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send(make_req(OP_SET, 512, 1, 0));
		send(make_req(OP_SET, 512, 32'h0001_0000, 0));
		send(make_req(OP_WDRAW, 0, 0, 32'h0));
		send(make_req(OP_WDRAW, 0, 0, 32'hFFFF_FFFF));
		send(make_req(OP_SET, 5, 32'hAAAA_AAAA, 0));
		send(make_req(OP_SET, 5, 32'h0, 0));
		send(make_req(OP_REMOVE, 5, 0, 0));
		send(make_req(OP_SET, 341, 32'h5555_5555, 0));
		send(make_req(OP_SET, 682, 32'hAAAA_AAAA, 0));
		send(make_req(OP_UDRAW, 0, 0, 32'hFFFF_FFFF));
		send(make_req(OP_UDRAW, 0, 0, 32'h0000_0002));
		send(req_t'({3'd5, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}));
		send(req_t'({3'd7, 10'h0, 32'h0, 32'h0}));
		send(make_req(OP_REMOVE, KEYS-1, 32'hFFFF_FFFF, 0));
		send(make_req(OP_CLEAR, 0, 0, 0));
		send(make_req(OP_UDRAW, 0, 0, 32'h1234_5678));

		// Random: mostly fill-then-draw sequences, with some noise.
		while (requests_sent < 560) begin
			if (requests_sent > 200 && !long_hold)
				long_hold = 1'b1;
			n = $urandom_range(2, 12);
			repeat (n) begin
				w = rand_weight();
				send(make_req(OP_SET, small_key(), w, $urandom));
				maybe_gap();
			end
			n = $urandom_range(1, 10);
			repeat (n) begin
				case ($urandom_range(0, 19))
					0, 1:    op = OP_REMOVE;
					2:       op = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_SET;
					3:       op = OP_SET;
					4:       op = op_t'($urandom_range(5, 7));
					default: op = $urandom_range(0, 1) ? OP_WDRAW : OP_UDRAW;
				endcase
				send(req_t'({op, KEY_W'(small_key()), rand_weight(), 32'($urandom)}));
				maybe_gap();
			end
		end
		req_valid <= 1'b0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (1100) @(posedge clk);
		$display("Sent %0d requests; %0d draws found a key, %0d met an empty table.",
			requests_sent, draws_found, draws_empty);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/wrst_pkg.sv
rtl/core/wrst_ram.sv
rtl/core/wrst_mod.sv
rtl/core/weighted_random_selection_table_unit.sv
tb/wrst_checker.sv
tb/tb_top.sv
